[hdl/elps_pkg.sv]
package elps_pkg;

    // Fixed field widths
    localparam int CMD_W      = 1;
    localparam int SLOT_W     = 4;
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ELLIPSE_COUNT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_RED   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_GREEN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_BLUE  = 4'd3;

    // Reset values
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd0;
    localparam logic [COLOR_W-1:0] BG_RESET    = 8'hd0;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    // Tag that travels with each table read through the test pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_eval_ctl;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
        t_rgb color;
    } t_eval_res;

endpackage

[hdl/ellipse_layer_pixel_shader_core.sv]
// Ellipse layer pixel shader.
// Input channel (i_in_valid / o_in_stall): one word per command. A load
// command writes one ellipse into table slot i_entry_index and gives no
// result. A pixel command gives one result word on the output channel
// (o_out_valid / i_out_stall): the fill color of the lowest-indexed ellipse
// among the first ellipse_count slots that contains the pixel, else the
// background color with o_covered low.
// The user must write registers through i_cfg_we / i_cfg_index / i_cfg_data
// only while the block is idle; the block itself does not enforce it.
// Timing: a load leaves the block idle. A pixel command with
// n = min(ellipse_count, MAX_ELLIPSES) slots reads n table entries; the
// next command can be accepted in the same cycle as its result can first
// be taken. The table RAM gives one entry per cycle into a four-stage test
// pipeline, so the slot walk and pipeline depth set its latency.
// One command is in work at a time; a finished result sits in the output
// register, and while the receiver stalls the next command can still be
// taken and worked on, but its result waits until the register frees.
// Reset clears the control state, sets ellipse_count to 0 and the
// background to 0xd0 gray. Table contents are undefined until loaded.
module ellipse_layer_pixel_shader_core #(
    parameter int MAX_ELLIPSES = 16,
    parameter int COORD_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [elps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [elps_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [elps_pkg::CMD_W-1:0]      i_command,
    input  logic [elps_pkg::SLOT_W-1:0]     i_entry_index,
    input  logic [COORD_BITS-1:0]           i_centre_x,
    input  logic [COORD_BITS-1:0]           i_centre_y,
    input  logic [COORD_BITS-1:0]           i_radius_x,
    input  logic [COORD_BITS-1:0]           i_radius_y,
    input  logic [elps_pkg::COLOR_W-1:0]    i_fill_red,
    input  logic [elps_pkg::COLOR_W-1:0]    i_fill_green,
    input  logic [elps_pkg::COLOR_W-1:0]    i_fill_blue,
    input  logic [COORD_BITS-1:0]           i_pixel_x,
    input  logic [COORD_BITS-1:0]           i_pixel_y,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [elps_pkg::COLOR_W-1:0]    o_pixel_red,
    output logic [elps_pkg::COLOR_W-1:0]    o_pixel_green,
    output logic [elps_pkg::COLOR_W-1:0]    o_pixel_blue,
    output logic                            o_covered
);

    import elps_pkg::*;

    localparam int ENTRY_W = 4 * COORD_BITS + RGB_W;
    localparam int IDX_W   = (MAX_ELLIPSES > 1) ? $clog2(MAX_ELLIPSES) : 1;
    localparam int CNT_W   = $clog2(MAX_ELLIPSES + 1);
    localparam int NCMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SCMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                r_state;
    logic [COUNT_W-1:0]    r_ellipse_count;
    t_rgb                  r_bg;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [CNT_W-1:0]      r_num;
    logic [CNT_W-1:0]      r_issue;
    logic                  r_found;
    t_rgb                  r_color;
    t_eval_ctl             r_rd_ctl;
    logic                  r_out_valid;
    t_rgb                  r_out_color;
    logic                  r_out_covered;

    logic             in_accept;
    logic             slot_ok;
    logic             wr_en;
    logic [CNT_W-1:0] n_num;
    logic [CNT_W-1:0] n_issue;
    logic             issue;
    logic             out_load;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    t_eval_res        res;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    assign slot_ok = SCMP_W'(i_entry_index) < SCMP_W'(MAX_ELLIPSES);
    assign wr_en   = in_accept && (i_command == CMD_LOAD) && slot_ok;
    assign wr_data = {i_centre_x, i_centre_y, i_radius_x, i_radius_y,
                      i_fill_red, i_fill_green, i_fill_blue};

    // clamp the tested count to the table depth
    assign n_num = (NCMP_W'(r_ellipse_count) < NCMP_W'(MAX_ELLIPSES)) ?
                   CNT_W'(r_ellipse_count) : CNT_W'(MAX_ELLIPSES);

    assign issue   = (r_state == ST_SCAN) && (r_issue < r_num);
    assign n_issue = r_issue + 1'b1;

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    elps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ELLIPSES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(i_entry_index)),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    elps_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_rd_ctl),
        .i_entry   (rd_data),
        .i_pixel_x (r_px),
        .i_pixel_y (r_py),
        .o_res     (res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ellipse_count <= COUNT_RESET;
            r_bg.red        <= BG_RESET;
            r_bg.green      <= BG_RESET;
            r_bg.blue       <= BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ELLIPSE_COUNT:    r_ellipse_count <= i_cfg_data[COUNT_W-1:0];
                CFG_BACKGROUND_RED:   r_bg.red        <= i_cfg_data[COLOR_W-1:0];
                CFG_BACKGROUND_GREEN: r_bg.green      <= i_cfg_data[COLOR_W-1:0];
                CFG_BACKGROUND_BLUE:  r_bg.blue       <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issue  <= '0;
            r_num    <= '0;
            r_found  <= 1'b0;
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl.valid <= issue;
            r_rd_ctl.last  <= issue && (n_issue == r_num);
            case (r_state)
                ST_IDLE: begin
                    if (in_accept && (i_command == CMD_PIXEL)) begin
                        r_num   <= n_num;
                        r_issue <= '0;
                        r_found <= 1'b0;
                        r_state <= (n_num == '0) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_issue <= n_issue;
                    end
                    // keep the first hit, drop later ones
                    if (res.valid && res.hit && !r_found) begin
                        r_found <= 1'b1;
                    end
                    if (res.valid && res.last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (i_command == CMD_PIXEL)) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if ((r_state == ST_SCAN) && res.valid && res.hit && !r_found) begin
            r_color <= res.color;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_color   <= r_found ? r_color : r_bg;
            r_out_covered <= r_found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_red   = r_out_color.red;
    assign o_pixel_green = r_out_color.green;
    assign o_pixel_blue  = r_out_color.blue;
    assign o_covered     = r_out_covered;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_res_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> (r_state == ST_SCAN))
        else $error("test result outside of a scan");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issue <= r_num))
        else $error("slot walk ran past the tested count");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> !r_rd_ctl.valid && !res.valid)
        else $error("command taken with table reads in flight");

    a_covered_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid && (o_covered == $past(r_found)))
        else $error("result word does not match the scan outcome");

endmodule

[hdl/elps_ram.sv]
module elps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/elps_eval.sv]
module elps_eval #(
    parameter int COORD_BITS = 10,
    parameter int ENTRY_W = 4 * COORD_BITS + elps_pkg::RGB_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  elps_pkg::t_eval_ctl    i_ctl,
    input  logic [ENTRY_W-1:0]     i_entry,
    input  logic [COORD_BITS-1:0]  i_pixel_x,
    input  logic [COORD_BITS-1:0]  i_pixel_y,
    output elps_pkg::t_eval_res    o_res
);

    import elps_pkg::*;

    localparam int C = COORD_BITS;

    logic [C-1:0] cx;
    logic [C-1:0] cy;
    logic [C-1:0] rx;
    logic [C-1:0] ry;
    t_rgb         color;

    // stage 1: distances to the center
    t_eval_ctl    r_ctl1;
    logic [C-1:0] r_dx;
    logic [C-1:0] r_dy;
    logic [C-1:0] r_rx;
    logic [C-1:0] r_ry;
    t_rgb         r_color1;
    logic [C-1:0] n_dx;
    logic [C-1:0] n_dy;

    // stage 2: scaled distances and radius product
    t_eval_ctl      r_ctl2;
    logic [2*C-1:0] r_tx;
    logic [2*C-1:0] r_ty;
    logic [2*C-1:0] r_tr;
    t_rgb           r_color2;

    // stage 3: squares
    t_eval_ctl      r_ctl3;
    logic [4*C-1:0] r_sx;
    logic [4*C-1:0] r_sy;
    logic [4*C-1:0] r_rr;
    t_rgb           r_color3;

    // stage 4: compare
    t_eval_ctl      r_ctl4;
    logic           r_hit;
    t_rgb           r_color4;
    logic           n_hit;

    assign cx    = i_entry[4*C+RGB_W-1 -: C];
    assign cy    = i_entry[3*C+RGB_W-1 -: C];
    assign rx    = i_entry[2*C+RGB_W-1 -: C];
    assign ry    = i_entry[C+RGB_W-1 -: C];
    assign color = t_rgb'(i_entry[RGB_W-1:0]);

    assign n_dx = (i_pixel_x >= cx) ? (i_pixel_x - cx) : (cx - i_pixel_x);
    assign n_dy = (i_pixel_y >= cy) ? (i_pixel_y - cy) : (cy - i_pixel_y);

    // sum is one bit wider than the squares so it never wraps
    assign n_hit = ((4*C+1)'(r_sx) + (4*C+1)'(r_sy)) <= (4*C+1)'(r_rr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_rx     <= rx;
        r_ry     <= ry;
        r_color1 <= color;

        r_tx     <= (2*C)'(r_dx) * (2*C)'(r_ry);
        r_ty     <= (2*C)'(r_dy) * (2*C)'(r_rx);
        r_tr     <= (2*C)'(r_rx) * (2*C)'(r_ry);
        r_color2 <= r_color1;

        r_sx     <= (4*C)'(r_tx) * (4*C)'(r_tx);
        r_sy     <= (4*C)'(r_ty) * (4*C)'(r_ty);
        r_rr     <= (4*C)'(r_tr) * (4*C)'(r_tr);
        r_color3 <= r_color2;

        r_hit    <= n_hit;
        r_color4 <= r_color3;
    end

    assign o_res = {r_ctl4, r_hit, r_color4};

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import elps_pkg::*;

    localparam int NUM_SLOTS     = 16;
    localparam int COORD_W       = 10;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int MAX_IDLE      = 17;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 13;
    localparam int PHASE_WORDS   = 125;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_BACKGROUND_BLUE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = '1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        t_rgb               fill;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } shader_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        t_rgb               fill;
    } ellipse_t;

    typedef struct packed {
        t_rgb color;
        logic covered;
    } shade_t;

    typedef enum {ROW_WORD, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e               kind;
        shader_word_t            w;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_data;
        bit                      typed;
        shade_t                  want;
    } script_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [CMD_W-1:0]        i_command;
    logic [SLOT_W-1:0]       i_entry_index;
    logic [COORD_W-1:0]      i_centre_x;
    logic [COORD_W-1:0]      i_centre_y;
    logic [COORD_W-1:0]      i_radius_x;
    logic [COORD_W-1:0]      i_radius_y;
    logic [COLOR_W-1:0]      i_fill_red;
    logic [COLOR_W-1:0]      i_fill_green;
    logic [COLOR_W-1:0]      i_fill_blue;
    logic [COORD_W-1:0]      i_pixel_x;
    logic [COORD_W-1:0]      i_pixel_y;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [COLOR_W-1:0]      o_pixel_red;
    logic [COLOR_W-1:0]      o_pixel_green;
    logic [COLOR_W-1:0]      o_pixel_blue;
    logic                    o_covered;

    // predictor state
    ellipse_t                shape_table [NUM_SLOTS];
    logic [COUNT_W-1:0]      lit_count = COUNT_RESET;
    t_rgb                    bg_color = {BG_RESET, BG_RESET, BG_RESET};

    shade_t                  pending_shades [$];
    int                      mismatches = 0;
    int                      cycle_count = 0;
    int                      out_wait = 0;
    bit                      in_idle_on = 1'b1;
    bit                      out_idle_on = 1'b1;

    ellipse_layer_pixel_shader_core #(
        .MAX_ELLIPSES (NUM_SLOTS),
        .COORD_BITS   (COORD_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_centre_x    (i_centre_x),
        .i_centre_y    (i_centre_y),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .i_fill_red    (i_fill_red),
        .i_fill_green  (i_fill_green),
        .i_fill_blue   (i_fill_blue),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_red   (o_pixel_red),
        .o_pixel_green (o_pixel_green),
        .o_pixel_blue  (o_pixel_blue),
        .o_covered     (o_covered)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Exact test, 64-bit products never wrap at these widths
    function automatic bit encloses(input ellipse_t e, input logic [COORD_W-1:0] px,
                                    input logic [COORD_W-1:0] py);
        longint unsigned dx, dy, tx, ty, tr;
        dx = (px >= e.cx) ? 64'(px - e.cx) : 64'(e.cx - px);
        dy = (py >= e.cy) ? 64'(py - e.cy) : 64'(e.cy - py);
        tx = dx * 64'(e.ry);
        ty = dy * 64'(e.rx);
        tr = 64'(e.rx) * 64'(e.ry);
        return (tx * tx + ty * ty) <= tr * tr;
    endfunction

    function automatic shade_t shade_pixel(input logic [COORD_W-1:0] px,
                                           input logic [COORD_W-1:0] py);
        shade_t s;
        int     n;
        s = {bg_color, 1'b0};
        n = (int'(lit_count) > NUM_SLOTS) ? NUM_SLOTS : int'(lit_count);
        // walk down so the lowest slot that hits wins
        for (int k = n - 1; k >= 0; k--)
            if (encloses(shape_table[k], px, py))
                s = {shape_table[k].fill, 1'b1};
        return s;
    endfunction

    function automatic script_row_t blank_row(input row_kind_e kind);
        script_row_t r;
        r.kind     = kind;
        r.w        = '0;
        r.reg_idx  = CFG_ELLIPSE_COUNT;
        r.reg_data = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic script_row_t load_row(input int slot, input int cx, input int cy,
                                             input int rx, input int ry, input t_rgb fill);
        script_row_t r;
        r = blank_row(ROW_WORD);
        r.w.command = CMD_LOAD;
        r.w.slot    = SLOT_W'(slot);
        r.w.cx      = COORD_W'(cx);
        r.w.cy      = COORD_W'(cy);
        r.w.rx      = COORD_W'(rx);
        r.w.ry      = COORD_W'(ry);
        r.w.fill    = fill;
        return r;
    endfunction

    function automatic script_row_t pixel_row(input int px, input int py, input bit typed,
                                              input shade_t want);
        script_row_t r;
        r = blank_row(ROW_WORD);
        r.w.command = CMD_PIXEL;
        r.w.px      = COORD_W'(px);
        r.w.py      = COORD_W'(py);
        r.typed     = typed;
        r.want      = want;
        return r;
    endfunction

    function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        script_row_t r;
        r = blank_row(ROW_REG);
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    task automatic issue_word(input shader_word_t w, input bit typed, input shade_t want);
        int gap;
        gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= w.command;
        i_entry_index <= w.slot;
        i_centre_x    <= w.cx;
        i_centre_y    <= w.cy;
        i_radius_x    <= w.rx;
        i_radius_y    <= w.ry;
        i_fill_red    <= w.fill.red;
        i_fill_green  <= w.fill.green;
        i_fill_blue   <= w.fill.blue;
        i_pixel_x     <= w.px;
        i_pixel_y     <= w.py;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (w.command == CMD_LOAD)
            shape_table[w.slot] = {w.cx, w.cy, w.rx, w.ry, w.fill};
        else
            pending_shades.push_back(typed ? want : shade_pixel(w.px, w.py));
    endtask

    // Hold the sender until every pixel word is back, then let a load finish
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_shades.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_ELLIPSE_COUNT:    lit_count = data[COUNT_W-1:0];
            CFG_BACKGROUND_RED:   bg_color.red = data;
            CFG_BACKGROUND_GREEN: bg_color.green = data;
            CFG_BACKGROUND_BLUE:  bg_color.blue = data;
            default: ;
        endcase
    endtask

    // Receiver: check each accepted word, then draw the stall before the next
    always @(posedge i_clk) begin
        shade_t got, want;
        if (o_out_valid && !i_out_stall) begin
            got = {o_pixel_red, o_pixel_green, o_pixel_blue, o_covered};
            if (pending_shades.size() == 0) begin
                $display("%0t: pixel word expected none, got rgb %h_%h_%h covered %b", $time,
                         got.color.red, got.color.green, got.color.blue, got.covered);
                mismatches++;
            end else begin
                want = pending_shades.pop_front();
                if (got !== want) begin
                    $display("%0t: pixel word expected rgb %h_%h_%h covered %b, got %h_%h_%h covered %b",
                             $time, want.color.red, want.color.green, want.color.blue,
                             want.covered, got.color.red, got.color.green, got.color.blue,
                             got.covered);
                    mismatches++;
                end
            end
            out_wait = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        end
        if (out_wait > 0) begin
            i_out_stall <= 1'b1;
            out_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        script_row_t           script [$];
        shader_word_t          w;
        ellipse_t              e;
        int                    n, off_x, off_y, sel;
        logic [CFG_DATA_W-1:0] count_data;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_ELLIPSE_COUNT;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_LOAD;
        i_entry_index <= '0;
        i_centre_x    <= '0;
        i_centre_y    <= '0;
        i_radius_x    <= '0;
        i_radius_y    <= '0;
        i_fill_red    <= '0;
        i_fill_green  <= '0;
        i_fill_blue   <= '0;
        i_pixel_x     <= '0;
        i_pixel_y     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no slot tested after reset: gray background
        script.push_back(pixel_row(0, 0, 1'b1, {BG_RESET, BG_RESET, BG_RESET, 1'b0}));
        script.push_back(reg_row(CFG_FIRST_UNUSED, 8'h00));
        script.push_back(reg_row(CFG_LAST_INDEX, 8'hff));
        script.push_back(pixel_row(COORD_MAX, COORD_MAX, 1'b1,
                                   {BG_RESET, BG_RESET, BG_RESET, 1'b0}));
        script.push_back(reg_row(CFG_BACKGROUND_RED, 8'h00));
        script.push_back(reg_row(CFG_BACKGROUND_GREEN, 8'hff));
        script.push_back(reg_row(CFG_BACKGROUND_BLUE, 8'h5a));
        script.push_back(load_row(0, 512, 512, 100, 50, {8'hff, 8'h00, 8'h00}));
        script.push_back(load_row(1, 0, 0, COORD_MAX, COORD_MAX, {8'h00, 8'hff, 8'h00}));
        // zero horizontal radius: only the centre column qualifies
        script.push_back(load_row(2, COORD_MAX, 0, 0, 40, {8'h00, 8'h00, 8'hff}));
        for (int s = 3; s < NUM_SLOTS - 1; s++)
            script.push_back(load_row(s, s * 64, 1000, 3, 2, {8'(s * 16), 8'(s), 8'hc3}));
        // both radii zero: every pixel qualifies
        script.push_back(load_row(NUM_SLOTS - 1, COORD_MAX, COORD_MAX, 0, 0,
                                  {8'h01, 8'h02, 8'h03}));
        script.push_back(reg_row(CFG_ELLIPSE_COUNT, 8'd1));
        script.push_back(pixel_row(612, 512, 1'b1, {8'hff, 8'h00, 8'h00, 1'b1}));
        script.push_back(pixel_row(613, 512, 1'b1, {8'h00, 8'hff, 8'h5a, 1'b0}));
        script.push_back(pixel_row(512, 562, 1'b1, {8'hff, 8'h00, 8'h00, 1'b1}));
        script.push_back(reg_row(CFG_ELLIPSE_COUNT, 8'(NUM_SLOTS)));
        script.push_back(pixel_row(COORD_MAX, COORD_MAX, 1'b0, '0));
        script.push_back(pixel_row(1000, 1000, 1'b0, '0));
        script.push_back(pixel_row(192, 1000, 1'b0, '0));
        // count above the table size, upper bits of the data dropped
        script.push_back(reg_row(CFG_ELLIPSE_COUNT, 8'hff));
        script.push_back(pixel_row(1000, 1000, 1'b0, '0));
        script.push_back(pixel_row(0, 0, 1'b0, '0));

        foreach (script[r]) begin
            if (script[r].kind == ROW_REG) begin
                if (r == 0 || script[r - 1].kind != ROW_REG)
                    drain_results();
                program_reg(script[r].reg_idx, script[r].reg_data);
            end else begin
                issue_word(script[r].w, script[r].typed, script[r].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                5: begin in_idle_on = 1'b0; out_idle_on = 1'b0; end
                6: begin in_idle_on = 1'b1; out_idle_on = 1'b0; end
                7: begin in_idle_on = 1'b0; out_idle_on = 1'b1; end
                default: begin
                    in_idle_on  = ($urandom_range(0, 3) != 0);
                    out_idle_on = ($urandom_range(0, 3) != 0);
                end
            endcase
            case (phase)
                0: count_data = '0;
                1: count_data = CFG_DATA_W'(NUM_SLOTS);
                2: count_data = '1;
                3: count_data = CFG_DATA_W'(NUM_SLOTS + 1);
                default: count_data = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                  : $urandom_range(1, NUM_SLOTS));
            endcase
            program_reg(CFG_ELLIPSE_COUNT, count_data);
            program_reg(CFG_BACKGROUND_RED,
                        (phase == 3) ? 8'h00 : (phase == 4) ? 8'hff : CFG_DATA_W'($urandom));
            program_reg(CFG_BACKGROUND_GREEN,
                        (phase == 3) ? 8'h00 : (phase == 4) ? 8'hff : CFG_DATA_W'($urandom));
            program_reg(CFG_BACKGROUND_BLUE,
                        (phase == 3) ? 8'h00 : (phase == 4) ? 8'hff : CFG_DATA_W'($urandom));
            if ($urandom_range(0, 1))
                program_reg(CFG_IDX_W'(int'(CFG_FIRST_UNUSED) +
                                       $urandom_range(0, CFG_LAST_INDEX - CFG_FIRST_UNUSED)),
                            CFG_DATA_W'($urandom));

            n = (int'(lit_count) > NUM_SLOTS) ? NUM_SLOTS : int'(lit_count);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                w.command = ($urandom_range(0, 99) < 18) ? CMD_LOAD : CMD_PIXEL;
                w.slot    = SLOT_W'($urandom);
                w.cx      = COORD_W'($urandom);
                w.cy      = COORD_W'($urandom);
                w.fill    = RGB_W'($urandom);
                w.px      = COORD_W'($urandom);
                w.py      = COORD_W'($urandom);
                sel  = $urandom_range(0, 9);
                w.rx = COORD_W'((sel < 5) ? $urandom_range(0, 63)
                                : (sel < 9) ? $urandom_range(0, 300) : $urandom);
                sel  = $urandom_range(0, 9);
                w.ry = COORD_W'((sel < 5) ? $urandom_range(0, 63)
                                : (sel < 9) ? $urandom_range(0, 300) : $urandom);
                // aim most pixel words at or near a tested ellipse
                if (w.command == CMD_PIXEL && n > 0 && $urandom_range(0, 9) < 7) begin
                    e     = shape_table[$urandom_range(0, n - 1)];
                    off_x = $urandom_range(0, int'(e.rx) + 2);
                    off_y = $urandom_range(0, int'(e.ry) + 2);
                    sel   = $urandom_range(0, 7);
                    if (sel == 0) begin
                        off_x = int'(e.rx);
                        off_y = 0;
                    end else if (sel == 1) begin
                        off_x = 0;
                        off_y = int'(e.ry);
                    end
                    if ($urandom_range(0, 1)) off_x = -off_x;
                    if ($urandom_range(0, 1)) off_y = -off_y;
                    off_x = off_x + int'(e.cx);
                    off_y = off_y + int'(e.cy);
                    if (off_x < 0) off_x = 0;
                    if (off_x > COORD_MAX) off_x = COORD_MAX;
                    if (off_y < 0) off_y = 0;
                    if (off_y > COORD_MAX) off_y = COORD_MAX;
                    w.px = COORD_W'(off_x);
                    w.py = COORD_W'(off_y);
                end
                issue_word(w, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
